[hdl/hkx_pkg.sv]
// Shared types and constants for the header-keyed XOR stream decrypt unit.
`timescale 1ns / 1ps
`default_nettype none
package hkx_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DATA    = 2'd0,
    STATUS_BAD_TAG = 2'd1,
    STATUS_BAD_VER = 2'd2
  } status_t;

  // Stream phase, one-hot
  typedef enum logic [3:0] {
    MODE_HEADER    = 4'b0001,
    MODE_AWAIT_KEY = 4'b0010,
    MODE_DATA      = 4'b0100,
    MODE_DROP      = 4'b1000
  } mode_t;

  localparam int unsigned POS_W       = 5;
  localparam int unsigned TAG_LEN     = 22;
  localparam logic [POS_W-1:0] TAG_LAST    = POS_W'(TAG_LEN - 1);
  localparam logic [POS_W-1:0] VER_POS_0   = 5'd22;
  localparam logic [POS_W-1:0] VER_POS_1   = 5'd24;
  localparam logic [POS_W-1:0] VER_POS_2   = 5'd26;
  localparam logic [POS_W-1:0] HDR_LAST    = 5'd27;
  localparam logic [POS_W-1:0] DATA_OFFSET = 5'd28;

  localparam logic [7:0] KEY_V111      = 8'hAC;
  localparam logic [7:0] KEY_V121_MASK = 8'hC1;
  localparam logic [7:0] CHAR_ONE      = 8'h31;
  localparam logic [7:0] CHAR_TWO      = 8'h32;

  // Version candidate flag bits
  localparam int unsigned VER_111 = 0;
  localparam int unsigned VER_121 = 1;

  // Fixed UTF-16LE header tag
  localparam logic [7:0] TAG_BYTES [TAG_LEN] = '{
    8'h4C, 8'h00, 8'h69, 8'h00, 8'h6E, 8'h00, 8'h65, 8'h00,
    8'h61, 8'h00, 8'h67, 8'h00, 8'h65, 8'h00, 8'h32, 8'h00,
    8'h56, 8'h00, 8'h65, 8'h00, 8'h72, 8'h00
  };

  // Expected tag byte at a header offset; zero past the tag
  function automatic logic [7:0] tag_byte(input logic [POS_W-1:0] pos);
    logic [7:0] val;
    val = 8'h00;
    if (pos <= TAG_LAST) begin
      val = TAG_BYTES[pos];
    end
    return val;
  endfunction

endpackage
`default_nettype wire

[hdl/hkx_stream_if.sv]
// Valid/ready channel interfaces for raw file bytes and decrypted results.
`timescale 1ns / 1ps
`default_nettype none
interface hkx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

interface hkx_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  hkx_pkg::status_t status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface
`default_nettype wire

[hdl/header_keyed_xor_stream_decrypt_unit.sv]
// Header-keyed XOR stream decrypt unit: header check, key select and data XOR.
//
// Takes one file byte per beat and accepts a new beat every cycle, also while
// a finished result waits in the output register, as long as that result is
// taken in the same cycle. Each beat passes through one level of compare/XOR
// logic into the result register, so a result appears in the cycle after its
// byte is accepted. Header bytes 0 to 27 give no result unless they carry an
// error (bad tag on byte 21, unknown version on byte 27); after an error the
// unit drops bytes until the next beat with start_of_file set. From byte 28
// on every byte is returned XORed with the selected key.
`timescale 1ns / 1ps
`default_nettype none
module header_keyed_xor_stream_decrypt_unit (
  input  wire logic clk,
  input  wire logic rst,
  hkx_in_if.sink    in_ch,
  hkx_out_if.source out_ch
);
  import hkx_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  mode_t            mode;
  mode_t            mode_next;
  logic             mismatch;
  logic             mismatch_next;
  logic [1:0]       ver_flags;
  logic [1:0]       ver_flags_next;
  logic [7:0]       key;
  logic [7:0]       key_next;

  logic             accept;
  logic             emit;
  logic [7:0]       emit_byte;
  status_t          emit_status;

  logic [POS_W-1:0] cur_pos;
  mode_t            cur_mode;
  logic             cur_mismatch;
  logic [1:0]       cur_flags;
  logic [7:0]       cur_key;
  logic [7:0]       b;

  // Take a beat whenever the result register is free or being emptied
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  // Start of file restarts recognition before this byte is handled
  always_comb begin
    if (in_ch.start_of_file) begin
      cur_pos      = '0;
      cur_mode     = MODE_HEADER;
      cur_mismatch = 1'b0;
      cur_flags    = 2'b11;
      cur_key      = 8'h00;
    end else begin
      cur_pos      = pos;
      cur_mode     = mode;
      cur_mismatch = mismatch;
      cur_flags    = ver_flags;
      cur_key      = key;
    end
  end

  // Per-byte state advance and result selection
  always_comb begin
    pos_next       = cur_pos;
    mode_next      = cur_mode;
    mismatch_next  = cur_mismatch;
    ver_flags_next = cur_flags;
    key_next       = cur_key;
    emit           = 1'b0;
    emit_byte      = 8'h00;
    emit_status    = STATUS_DATA;

    unique case (cur_mode)
      MODE_HEADER: begin
        // Tag compare and version digit checks
        if (cur_pos <= TAG_LAST) begin
          if (b != tag_byte(cur_pos)) begin
            mismatch_next = 1'b1;
          end
        end else if (cur_pos == VER_POS_0 || cur_pos == VER_POS_2) begin
          if (b != CHAR_ONE) begin
            ver_flags_next = 2'b00;
          end
        end else if (cur_pos == VER_POS_1) begin
          if (b != CHAR_ONE) begin
            ver_flags_next[VER_111] = 1'b0;
          end
          if (b != CHAR_TWO) begin
            ver_flags_next[VER_121] = 1'b0;
          end
        end

        if (cur_pos == TAG_LAST && mismatch_next) begin
          mode_next   = MODE_DROP;
          emit        = 1'b1;
          emit_status = STATUS_BAD_TAG;
        end else if (cur_pos >= HDR_LAST) begin
          pos_next = DATA_OFFSET;
          priority if (ver_flags_next[VER_111]) begin
            key_next  = KEY_V111;
            mode_next = MODE_DATA;
          end else if (ver_flags_next[VER_121]) begin
            mode_next = MODE_AWAIT_KEY;
          end else begin
            mode_next   = MODE_DROP;
            emit        = 1'b1;
            emit_status = STATUS_BAD_VER;
          end
        end else begin
          pos_next = cur_pos + 1'b1;
        end
      end
      MODE_AWAIT_KEY: begin
        // Key byte decrypts to the mask itself
        key_next  = b ^ KEY_V121_MASK;
        mode_next = MODE_DATA;
        emit      = 1'b1;
        emit_byte = KEY_V121_MASK;
      end
      MODE_DATA: begin
        emit      = 1'b1;
        emit_byte = b ^ cur_key;
      end
      MODE_DROP: begin
        emit = 1'b0;
      end
      default: begin
        mode_next = MODE_DROP;
      end
    endcase
  end

  // Advance recognition state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      mode      <= MODE_HEADER;
      mismatch  <= 1'b0;
      ver_flags <= 2'b11;
      key       <= 8'h00;
    end else if (accept) begin
      pos       <= pos_next;
      mode      <= mode_next;
      mismatch  <= mismatch_next;
      ver_flags <= ver_flags_next;
      key       <= key_next;
    end
  end

  // Hold result until taken, load a new one when it frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_ch.valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_ch.out_byte <= emit_byte;
      out_ch.status   <= emit_status;
    end
  end

endmodule
`default_nettype wire

[hdl/hkx_checker.sv]
// Port-level assertions for the header-keyed XOR stream decrypt unit.
`timescale 1ns / 1ps
`default_nettype none
module hkx_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       out_byte,
  input wire hkx_pkg::status_t status
);
  import hkx_pkg::*;

  // Error beats carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_BAD_TAG || status == STATUS_BAD_VER) |-> out_byte == 8'h00)
    else $error("error beat with nonzero byte");

  // Input side is open whenever no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
    else $error("stalled result changed");

endmodule

bind header_keyed_xor_stream_decrypt_unit hkx_checker u_hkx_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .status    (out_ch.status)
);
`default_nettype wire
